// ===== src/lfu_replacement_policy_defines.svh =====
// Assertion macros used by the checker file.
`ifndef LFU_REPLACEMENT_POLICY_DEFINES_SVH
`define LFU_REPLACEMENT_POLICY_DEFINES_SVH

// Generic form: explicit clock and active-low reset.
`define LFU_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Block default: clk_i / rst_ni.
`define LFU_ASSERT(lbl, prop, msg) \
  `LFU_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== src/lfu_pkg.sv =====
package lfu_pkg;

  localparam int unsigned KEY_W     = 32;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned OUT_CNT_W = 16;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // word index of the registers (paddr[2])
  localparam logic REG_CAPACITY = 1'b0;

endpackage

// ===== src/lfu_replacement_policy.sv =====
// LFU replacement policy for a small fully associative key store.
// Input channel: in_valid_i / in_stall_o carry one key reference word
// (ref_key_i). A word is taken when in_valid_i is high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carry one result word per
// reference: hit, stored, evicted, evicted_key, use_count_now.
// Config: APB-style port, capacity register at byte address 0, pready
// always high; write only while no reference is in flight.
// Timing: every reference scans all MAX_ENTRIES entries through the single
// read port of the entry RAM, one entry a cycle, then writes back one entry.
// The result register is loaded in ST_UPDATE after the scan and a drain
// step, and the next word is taken once the block is back in ST_IDLE. With
// capacity zero the scan is skipped and ST_UPDATE loads an all-zero result.
// Output is a register: a new reference is taken while a result is still
// stalled; the write-back then waits until the output register frees up.
// Reset: valid bits, occupancy, stamp clock and handshake state clear at
// once; capacity goes to 16. The RAM contents are not cleared.
module lfu_replacement_policy
  import lfu_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // reference input
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [KEY_W-1:0]     ref_key_i,
  // result output
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 hit_o,
  output logic                 stored_o,
  output logic                 evicted_o,
  output logic [KEY_W-1:0]     evicted_key_o,
  output logic [OUT_CNT_W-1:0] use_count_now_o,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned OW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW = (OW > CAP_W) ? OW : CAP_W;
  localparam logic [AW-1:0]         LastIdx  = AW'(MAX_ENTRIES - 1);
  localparam logic [CW-1:0]         MaxCap   = CW'(MAX_ENTRIES);
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } state_e;

  // ---------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------
  logic [CAP_W-1:0] capacity_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_q) : '0;

  // effective capacity: clamp to the store size
  logic [CW-1:0] cap_ext, cap_eff;
  assign cap_ext = CW'(capacity_q);
  assign cap_eff = (cap_ext > MaxCap) ? MaxCap : cap_ext;

  // ---------------------------------------------------------------
  // Entry RAM: one read port (scan), one write port (write-back)
  // ---------------------------------------------------------------
  logic [KEY_W-1:0]      key_mem   [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] count_mem [MAX_ENTRIES];
  logic [STAMP_W-1:0]    stamp_mem [MAX_ENTRIES];

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [COUNT_BITS-1:0] mem_wcount;
  logic [KEY_W-1:0]      rd_key_q;
  logic [COUNT_BITS-1:0] rd_cnt_q;
  logic [STAMP_W-1:0]    rd_stamp_q;
  logic [AW-1:0]         idx_q;
  logic [KEY_W-1:0]      key_q;
  logic [STAMP_W-1:0]    stamp_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_waddr]   <= key_q;
      count_mem[mem_waddr] <= mem_wcount;
      stamp_mem[mem_waddr] <= stamp_q;
    end
    rd_key_q   <= key_mem[idx_q];
    rd_cnt_q   <= count_mem[idx_q];
    rd_stamp_q <= stamp_mem[idx_q];
  end

  // ---------------------------------------------------------------
  // Sequencer and scan unit
  // ---------------------------------------------------------------
  state_e                state_q;
  logic [OW-1:0]         occ_q;
  logic [MAX_ENTRIES-1:0] valid_q;
  logic                  dis_q;      // capacity was zero at accept
  logic                  cmp_vld_q;  // rd_*_q holds entry cmp_idx_q
  logic [AW-1:0]         cmp_idx_q;

  logic                  hit_fnd_q;
  logic [AW-1:0]         hit_idx_q;
  logic [COUNT_BITS-1:0] hit_cnt_q;
  logic                  vic_fnd_q;
  logic [AW-1:0]         vic_idx_q;
  logic [COUNT_BITS-1:0] vic_cnt_q;
  logic [STAMP_W-1:0]    vic_stamp_q;
  logic [KEY_W-1:0]      vic_key_q;
  logic                  free_fnd_q;
  logic [AW-1:0]         free_idx_q;

  logic                  out_valid_q, hit_q, stored_q, evicted_q;
  logic [KEY_W-1:0]      evicted_key_q;
  logic [OUT_CNT_W-1:0]  use_cnt_q;

  // compare stage
  logic                  ent_vld, ent_hit, ent_lt;
  assign ent_vld = cmp_vld_q & valid_q[cmp_idx_q];
  assign ent_hit = ent_vld & (rd_key_q == key_q);
  // lower count wins, equal count: older stamp wins
  assign ent_lt  = {rd_cnt_q, rd_stamp_q} < {vic_cnt_q, vic_stamp_q};

  // write-back decision
  logic                  accept, out_free, do_update, full;
  logic [COUNT_BITS-1:0] hit_cnt_inc;
  logic [AW-1:0]         slot;

  assign accept      = in_valid_i & ~in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign do_update   = (state_q == ST_UPDATE) & out_free;
  assign full        = (CW'(occ_q) >= cap_eff);
  assign hit_cnt_inc = (hit_cnt_q == CountMax) ? hit_cnt_q : hit_cnt_q + CountOne;
  // a miss that finds the store full reuses the victim slot
  assign slot        = hit_fnd_q ? hit_idx_q : (full ? vic_idx_q : free_idx_q);

  assign mem_we     = do_update & ~dis_q;
  assign mem_waddr  = slot;
  assign mem_wcount = hit_fnd_q ? hit_cnt_inc : CountOne;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      key_q         <= '0;
      stamp_q       <= '0;
      occ_q         <= '0;
      valid_q       <= '0;
      dis_q         <= 1'b0;
      idx_q         <= '0;
      cmp_vld_q     <= 1'b0;
      cmp_idx_q     <= '0;
      hit_fnd_q     <= 1'b0;
      hit_idx_q     <= '0;
      hit_cnt_q     <= '0;
      vic_fnd_q     <= 1'b0;
      vic_idx_q     <= '0;
      vic_cnt_q     <= '0;
      vic_stamp_q   <= '0;
      vic_key_q     <= '0;
      free_fnd_q    <= 1'b0;
      free_idx_q    <= '0;
      out_valid_q   <= 1'b0;
      hit_q         <= 1'b0;
      stored_q      <= 1'b0;
      evicted_q     <= 1'b0;
      evicted_key_q <= '0;
      use_cnt_q     <= '0;
    end else begin
      // taken result drops, unless a new one replaces it at this edge
      if (out_valid_q && !out_stall_i && !do_update) begin
        out_valid_q <= 1'b0;
      end

      // compare stage runs behind the read port
      cmp_vld_q <= (state_q == ST_SCAN);
      cmp_idx_q <= idx_q;
      if (ent_hit && !hit_fnd_q) begin
        hit_fnd_q <= 1'b1;
        hit_idx_q <= cmp_idx_q;
        hit_cnt_q <= rd_cnt_q;
      end
      if (ent_vld && (!vic_fnd_q || ent_lt)) begin
        vic_fnd_q   <= 1'b1;
        vic_idx_q   <= cmp_idx_q;
        vic_cnt_q   <= rd_cnt_q;
        vic_stamp_q <= rd_stamp_q;
        vic_key_q   <= rd_key_q;
      end
      if (cmp_vld_q && !valid_q[cmp_idx_q] && !free_fnd_q) begin
        free_fnd_q <= 1'b1;
        free_idx_q <= cmp_idx_q;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            key_q      <= ref_key_i;
            dis_q      <= (cap_eff == '0);
            idx_q      <= '0;
            hit_fnd_q  <= 1'b0;
            vic_fnd_q  <= 1'b0;
            free_fnd_q <= 1'b0;
            state_q    <= (cap_eff == '0) ? ST_UPDATE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx_q == LastIdx) begin
            state_q <= ST_DRAIN;
          end else begin
            idx_q <= idx_q + AW'(1);
          end
        end
        ST_DRAIN: begin
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
            if (dis_q) begin
              hit_q         <= 1'b0;
              stored_q      <= 1'b0;
              evicted_q     <= 1'b0;
              evicted_key_q <= '0;
              use_cnt_q     <= '0;
            end else begin
              stamp_q <= stamp_q + STAMP_W'(1);
              if (hit_fnd_q) begin
                hit_q         <= 1'b1;
                stored_q      <= 1'b0;
                evicted_q     <= 1'b0;
                evicted_key_q <= '0;
                use_cnt_q     <= OUT_CNT_W'(hit_cnt_inc);
              end else begin
                hit_q         <= 1'b0;
                stored_q      <= 1'b1;
                evicted_q     <= full;
                evicted_key_q <= full ? vic_key_q : '0;
                use_cnt_q     <= OUT_CNT_W'(CountOne);
                valid_q[slot] <= 1'b1;
                if (!full) begin
                  occ_q <= occ_q + OW'(1);
                end
              end
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign stored_o        = stored_q;
  assign evicted_o       = evicted_q;
  assign evicted_key_o   = evicted_key_q;
  assign use_count_now_o = use_cnt_q;

endmodule

// ===== src/lfu_checker.sv =====
`include "lfu_replacement_policy_defines.svh"

module lfu_checker
  import lfu_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic                 hit_o,
  input logic                 stored_o,
  input logic                 evicted_o,
  input logic [KEY_W-1:0]     evicted_key_o,
  input logic [OUT_CNT_W-1:0] use_count_now_o
);

  // one reference at a time: busy right after taking a word
  `LFU_ASSERT(a_busy_after_accept,
    in_valid_i && !in_stall_o |=> in_stall_o,
    "input taken while a reference is in flight")

  // stalled result word holds
  `LFU_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(evicted_key_o)
      && $stable(use_count_now_o) && $stable({hit_o, stored_o, evicted_o}),
    "stalled result changed")

  // a hit never inserts or evicts; an eviction always inserts
  `LFU_ASSERT(a_flags,
    out_valid_o |-> !(hit_o && (stored_o || evicted_o)) && (!evicted_o || stored_o),
    "inconsistent result flags")

  // count and evicted key agree with the flags
  `LFU_ASSERT(a_fields,
    out_valid_o |-> (!stored_o || use_count_now_o == OUT_CNT_W'(1))
      && (evicted_o || evicted_key_o == '0)
      && (hit_o || stored_o || use_count_now_o == '0),
    "result fields disagree with flags")

endmodule

bind lfu_replacement_policy lfu_checker u_lfu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .hit_o           (hit_o),
  .stored_o        (stored_o),
  .evicted_o       (evicted_o),
  .evicted_key_o   (evicted_key_o),
  .use_count_now_o (use_count_now_o)
);

// ===== tb/tb.sv =====
module tb;
  import lfu_pkg::*;

  // Block size as instantiated (defaults of the block).
  localparam int unsigned N_ENTRIES = 16;
  localparam logic [OUT_CNT_W-1:0] CNT_TOP = '1;   // COUNT_BITS == OUT_CNT_W here
  // Cycles with no word moving on either channel before the run is called dead.
  // A single reference and the random gaps and stalls all stay far below this.
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned POOL_N = 24;
  localparam int unsigned BUF_N = 4096;

  typedef struct packed {
    logic                 hit;
    logic                 stored;
    logic                 evicted;
    logic [KEY_W-1:0]     ev_key;
    logic [OUT_CNT_W-1:0] use_cnt;
  } lfu_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // stimulus side, all known from time zero
  logic                 in_valid = 1'b0;
  logic [KEY_W-1:0]     ref_key  = '0;
  logic                 out_stall = 1'b0;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [PADDR_W-1:0]   paddr   = '0;
  logic [PDATA_W-1:0]   pwdata  = '0;

  logic                 in_stall;
  logic                 out_valid;
  logic                 hit;
  logic                 stored;
  logic                 evicted;
  logic [KEY_W-1:0]     evicted_key;
  logic [OUT_CNT_W-1:0] use_count_now;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  lfu_replacement_policy i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .ref_key_i       (ref_key),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .hit_o           (hit),
    .stored_o        (stored),
    .evicted_o       (evicted),
    .evicted_key_o   (evicted_key),
    .use_count_now_o (use_count_now),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // LFU shadow: own copy of the key store, stamp clock and capacity.
  // Updated once per accepted reference word, in acceptance order.
  // ---------------------------------------------------------------------------
  logic                 shadow_valid [N_ENTRIES];
  logic [KEY_W-1:0]     shadow_key   [N_ENTRIES];
  logic [OUT_CNT_W-1:0] shadow_cnt   [N_ENTRIES];
  logic [STAMP_W-1:0]   shadow_stamp [N_ENTRIES];
  logic [STAMP_W-1:0]   stamp_clock = '0;
  int unsigned          occupancy = 0;
  logic [CAP_W-1:0]     capacity_reg = CAP_RESET;

  // pending reference words and results still owed by the block (ring buffers)
  logic [KEY_W-1:0] key_buf [BUF_N];
  int unsigned      key_wr = 0;
  int unsigned      key_rd = 0;
  lfu_result_t      exp_buf [BUF_N];
  int unsigned      exp_wr = 0;
  int unsigned      exp_rd = 0;

  int unsigned src_idle_pct = 0;   // sender idle chance per cycle
  int unsigned snk_stall_pct = 0;  // receiver stall chance per cycle
  int unsigned n_sent = 0;         // words handed to the driver
  int unsigned n_results = 0;      // results taken by the monitor
  int unsigned n_hits = 0;
  int unsigned n_evicts = 0;
  int unsigned n_cap_writes = 0;
  int unsigned n_errors = 0;
  int unsigned idle_cycles = 0;

  logic [KEY_W-1:0] key_pool [POOL_N];

  initial begin
    for (int i = 0; i < N_ENTRIES; i++) shadow_valid[i] = 1'b0;
  end

  // Next state of the store for one reference, and the result it owes.
  function automatic lfu_result_t lfu_lookup(logic [KEY_W-1:0] key);
    lfu_result_t r;
    int unsigned cap_eff;
    int slot;
    int victim;
    r = '0;
    slot = -1;
    victim = -1;
    cap_eff = (capacity_reg > N_ENTRIES) ? N_ENTRIES : capacity_reg;
    if (cap_eff == 0) return r;   // disabled: no change, all-zero result
    for (int i = 0; i < N_ENTRIES; i++) begin
      if (slot < 0 && shadow_valid[i] && shadow_key[i] == key) slot = i;
    end
    if (slot >= 0) begin
      // hit: saturate the count, always refresh the stamp
      if (shadow_cnt[slot] != CNT_TOP)
        shadow_cnt[slot] = shadow_cnt[slot] + OUT_CNT_W'(1);
      shadow_stamp[slot] = stamp_clock;
      stamp_clock = stamp_clock + STAMP_W'(1);
      r.hit = 1'b1;
      r.use_cnt = shadow_cnt[slot];
      n_hits++;
      return r;
    end
    if (occupancy >= cap_eff) begin
      // lowest count wins, oldest stamp breaks the tie
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (shadow_valid[i]) begin
          if (victim < 0 || shadow_cnt[i] < shadow_cnt[victim] ||
              (shadow_cnt[i] == shadow_cnt[victim] &&
               shadow_stamp[i] < shadow_stamp[victim]))
            victim = i;
        end
      end
      if (victim >= 0) begin
        // only one eviction, even when capacity sits below occupancy
        r.evicted = 1'b1;
        r.ev_key = shadow_key[victim];
        shadow_valid[victim] = 1'b0;
        occupancy--;
        slot = victim;
        n_evicts++;
      end
    end
    if (slot < 0) begin
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (slot < 0 && !shadow_valid[i]) slot = i;
      end
    end
    if (slot >= 0) begin
      shadow_valid[slot] = 1'b1;
      shadow_key[slot] = key;
      shadow_cnt[slot] = OUT_CNT_W'(1);
      shadow_stamp[slot] = stamp_clock;
      stamp_clock = stamp_clock + STAMP_W'(1);
      occupancy++;
      r.stored = 1'b1;
      r.use_cnt = OUT_CNT_W'(1);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("%0t: %s got %h want %h (result %0d)", $realtime, what, got, want, n_results);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: feeds reference words from key_buf; payload held while stalled.
  // The shadow store is updated at the edge that takes the word.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        exp_buf[exp_wr % BUF_N] = lfu_lookup(ref_key);
        exp_wr++;
      end
      if (!in_valid || !in_stall) begin
        if (key_wr != key_rd && $urandom_range(99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          ref_key  <= key_buf[key_rd % BUF_N];
          key_rd++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stall, each taken result against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lfu_result_t want;
    if (rst_ni) begin
      out_stall <= ($urandom_range(99) < snk_stall_pct);
      if (out_valid && !out_stall) begin
        n_results++;
        if (exp_wr == exp_rd) begin
          report_mismatch("unexpected result, hit", 32'(hit), 32'd0);
        end else begin
          want = exp_buf[exp_rd % BUF_N];
          exp_rd++;
          if (hit !== want.hit)         report_mismatch("hit", 32'(hit), 32'(want.hit));
          if (stored !== want.stored)   report_mismatch("stored", 32'(stored), 32'(want.stored));
          if (evicted !== want.evicted)
            report_mismatch("evicted", 32'(evicted), 32'(want.evicted));
          if (evicted_key !== want.ev_key)
            report_mismatch("evicted_key", evicted_key, want.ev_key);
          if (use_count_now !== want.use_cnt)
            report_mismatch("use_count_now", 32'(use_count_now), 32'(want.use_cnt));
        end
      end
    end
  end

  // Watchdog: nothing moving on either channel for too long ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results owed",
                 STALL_LIMIT, exp_wr - exp_rd);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic push_key(logic [KEY_W-1:0] k);
    key_buf[key_wr % BUF_N] = k;
    key_wr++;
    n_sent++;
  endtask

  // every word sent has one result; equal counts mean the block is idle
  task automatic wait_drained();
    do @(posedge clk_i); while (n_results != n_sent);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write of capacity with junk in the upper bits, then read back.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    logic [PDATA_W-1:0] w;
    w = $urandom;
    w[CAP_W-1:0] = cap;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_CAPACITY, 2'b00});
    pwdata  <= w;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);   // register written here
    if (pready !== 1'b1) report_mismatch("pready", 32'(pready), 32'd1);
    capacity_reg = cap;
    n_cap_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);   // read access edge, sampled before it updates
    if (prdata !== PDATA_W'(cap)) report_mismatch("capacity readback", prdata, PDATA_W'(cap));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly keys from a pool a bit larger than capacity, some hot, some fresh.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned span;
    int unsigned r;
    span = ((capacity_reg > N_ENTRIES) ? N_ENTRIES : capacity_reg) + 4;
    if (span > POOL_N - 1) span = POOL_N - 1;
    r = $urandom_range(99);
    if (r < 12) return $urandom;
    if (r < 45) return key_pool[$urandom_range(span < 3 ? span : 3, 0)];
    return key_pool[$urandom_range(span, 0)];
  endfunction

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed corners, repeated hits, random phases.
  // ---------------------------------------------------------------------------
  initial begin
    logic [CAP_W-1:0] rand_caps [10];
    rand_caps = '{5'd16, 5'd1, 5'd4, 5'd17, 5'd3, 5'd0, 5'd8, 5'd2, 5'd31, 5'd16};
    for (int i = 0; i < POOL_N; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed at reset capacity: key extremes, first hit, fill, LFU eviction
    // with count ties going to the oldest entry.
    push_key(32'h0000_0000);
    push_key(32'hFFFF_FFFF);
    push_key(32'h0000_0000);
    push_key(32'hA5A5_A5A5);
    push_key(32'h5A5A_5A5A);
    for (int i = 0; i < 12; i++) push_key(32'h0000_0100 + i);
    push_key(32'h1234_5678);   // full: evicts the oldest count-1 entry
    push_key(32'hFFFF_FFFF);
    push_key(32'h0000_0000);
    wait_drained();

    // disabled: nothing changes, zero results
    write_capacity(5'd0);
    push_key(32'h0000_0000);
    push_key(32'hDEAD_BEEF);
    push_key(32'h5A5A_5A5A);
    wait_drained();

    // above the entry count: acts as full size
    write_capacity(5'd31);
    push_key(32'hCAFE_F00D);
    push_key(32'h0000_0000);
    wait_drained();

    // capacity far below occupancy: one eviction per miss, no shrinking
    write_capacity(5'd1);
    push_key(32'h7777_7777);
    push_key(32'h7777_7777);
    push_key(32'h8888_8888);
    wait_drained();

    // Repeated hits on one key, back to back, then a fresh key.
    write_capacity(5'd16);
    for (int i = 0; i < 8; i++) push_key(32'h0000_0000);
    push_key(32'h0BAD_F00D);
    wait_drained();

    // Random phases over several capacities and idle mixes.
    for (int p = 0; p < 10; p++) begin
      write_capacity(rand_caps[p]);
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 47; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 47; end
        default: begin src_idle_pct = 29; snk_stall_pct = 29; end
      endcase
      for (int i = 0; i < 182; i++) push_key(pick_key());
      wait_drained();
    end
    src_idle_pct = 0;
    snk_stall_pct = 0;

    // tail: catch any stray result
    repeat (40) @(posedge clk_i);
    if (exp_wr != exp_rd)
      report_mismatch("results never came", exp_wr - exp_rd, 32'd0);

    $display("Ran %0d key references: %0d hits, %0d evictions, %0d capacity writes,",
             n_sent, n_hits, n_evicts, n_cap_writes);
    $display("incl. disabled store, oversize and shrunk capacity, repeated hits.");
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
